>>> hdl/key_hash_shard_select_macros.svh
// Assertion macros for the key_hash_shard_select checker.
// Included by khss_checker.sv; the clock and reset are i_clk and i_rst_n.
`ifndef KEY_HASH_SHARD_SELECT_MACROS_SVH
`define KEY_HASH_SHARD_SELECT_MACROS_SVH

// Consequent checked in the cycle after the antecedent, outside reset.
`define KHSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same cycle, outside reset.
`define KHSS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checked through reset as well.
`define KHSS_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/khss_pkg.sv
// Shared constants and helpers for key_hash_shard_select.
// No dependencies; imported by the top level, the divider, the checkers and the testbench.
package khss_pkg;

    localparam int HASH_W    = 32;
    localparam int KEY_W     = 31;
    localparam int BYTE_W    = 8;
    localparam int SHARD_W   = 9;
    localparam int IDX_W     = 8;
    localparam int DIV_STEPS = KEY_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [BYTE_W-1:0]  SEP_BYTE    = 8'h3A;
    localparam logic [SHARD_W-1:0] MAX_SHARDS  = 9'd256;
    localparam logic [SHARD_W-1:0] SHARD_RESET = 9'd1;

    // Zero maps to one shard, anything above the maximum to the maximum.
    function automatic logic [SHARD_W-1:0] eff_shards(input logic [SHARD_W-1:0] n);
        logic [SHARD_W-1:0] r;
        if (n == '0) begin
            r = SHARD_W'(1);
        end else if (n > MAX_SHARDS) begin
            r = MAX_SHARDS;
        end else begin
            r = n;
        end
        return r;
    endfunction

endpackage

>>> hdl/key_hash_shard_select.sv
// key_hash_shard_select: SDBM hash of the parent account of a name, and its shard.
// Depends on khss_pkg and khss_divider.
//
// Name bytes stream in one per cycle while the input is not stalled; bytes before the
// first colon are folded into the SDBM hash (byte + h*65599, mod 2^32). On the last
// byte the 31-bit hash goes to the bit-serial remainder unit, which takes one hash bit
// per cycle before the result lands in the output register. The input is stalled
// while the remainder unit runs and while a finished result waits for a free
// output register. shard_count is taken as 1 when zero and 256 when larger.
module key_hash_shard_select
    import khss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SHARD_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_name_byte,
    input  logic               i_is_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [IDX_W-1:0]   o_shard_index,
    output logic [KEY_W-1:0]   o_key_hash
);

    typedef enum logic [1:0] {S_HASH, S_DIV, S_DONE} t_state;

    t_state             r_state;
    logic [SHARD_W-1:0] r_shards;
    logic [HASH_W-1:0]  r_hash;
    logic               r_past;
    logic [KEY_W-1:0]   r_key;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_shard_index;
    logic [KEY_W-1:0]   r_key_hash;

    logic               in_acc;
    logic               hashing;
    logic [HASH_W-1:0]  n_hash;
    logic [HASH_W-1:0]  h_now;
    logic               div_start;
    logic               div_done;
    logic [IDX_W-1:0]   div_rem;
    logic               out_free;
    logic               out_load;

    assign in_acc   = i_in_valid && (r_state == S_HASH);
    assign hashing  = !r_past && (i_name_byte != SEP_BYTE);
    assign n_hash   = HASH_W'(i_name_byte) + (r_hash << 6) + (r_hash << 16) - r_hash;
    assign h_now    = hashing ? n_hash : r_hash;
    assign div_start = in_acc && i_is_last;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = out_free && (((r_state == S_DIV) && div_done) || (r_state == S_DONE));

    khss_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (h_now[KEY_W-1:0]),
        .i_divisor   (eff_shards(r_shards)),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HASH;
            r_shards    <= SHARD_RESET;
            r_hash      <= '0;
            r_past      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_shards <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_HASH: begin
                    if (in_acc) begin
                        if (i_is_last) begin
                            r_hash  <= '0;
                            r_past  <= 1'b0;
                            r_key   <= h_now[KEY_W-1:0];
                            r_state <= S_DIV;
                        end else begin
                            r_hash <= h_now;
                            if (!r_past && (i_name_byte == SEP_BYTE)) begin
                                r_past <= 1'b1;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (out_free) begin
                            r_shard_index <= div_rem;
                            r_key_hash    <= r_key;
                            r_state       <= S_HASH;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_shard_index <= div_rem;
                        r_key_hash    <= r_key;
                        r_state       <= S_HASH;
                    end
                end
                default: begin
                    r_state <= S_HASH;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_HASH);
    assign o_out_valid   = r_out_valid;
    assign o_shard_index = r_shard_index;
    assign o_key_hash    = r_key_hash;

endmodule

>>> hdl/khss_divider.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on khss_pkg.
module khss_divider
    import khss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [KEY_W-1:0]   i_dividend,
    input  logic [SHARD_W-1:0] i_divisor,
    output logic               o_done,
    output logic [IDX_W-1:0]   o_remainder
);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [KEY_W-1:0]   r_dvd;
    logic [SHARD_W-1:0] r_dvs;
    logic [SHARD_W-1:0] r_rem;
    logic [SHARD_W:0]   trial;
    logic [SHARD_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[KEY_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = SHARD_W'(trial - {1'b0, r_dvs});
        end else begin
            n_rem = trial[SHARD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[KEY_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem[IDX_W-1:0];

endmodule

>>> hdl/khss_checker.sv
// Port-level checker for key_hash_shard_select, bound to the top level.
// Depends on khss_pkg and key_hash_shard_select_macros.svh.
`include "key_hash_shard_select_macros.svh"

module khss_assertions
    import khss_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_is_last,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [IDX_W-1:0]   o_shard_index,
    input logic [KEY_W-1:0]   o_key_hash
);

    // stalled result transaction holds
    `KHSS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_key_hash) && $stable(o_shard_index), "stalled result changed")
    // last byte starts the remainder pass
    `KHSS_ASSERT_NEXT(a_last_stalls, i_in_valid && !o_in_stall && i_is_last, o_in_stall, "input not stalled after last byte")
    // a new result only comes out of the remainder pass
    `KHSS_ASSERT_SAME(a_result_src, $rose(o_out_valid), $past(o_in_stall), "result without a pending name")
    `KHSS_ASSERT_RESET(a_reset_idle, !i_rst_n, !o_out_valid && !o_in_stall, "not idle after reset")

endmodule

bind key_hash_shard_select khss_assertions u_khss_assertions (.*);

>>> tb/sv/khss_checker.sv
// Checker for key_hash_shard_select: tracks the shard count register, predicts the
// SDBM hash and shard of every name from the accepted bytes and compares each result.
// Depends on khss_pkg.
module khss_checker
    import khss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SHARD_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [BYTE_W-1:0]  i_name_byte,
    input  logic               i_is_last,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [IDX_W-1:0]   i_shard_index,
    input  logic [KEY_W-1:0]   i_key_hash,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_W-1:0] shard;
        logic [KEY_W-1:0] hash;
    } t_shard_result;

    t_shard_result     shard_results_q[$];
    t_shard_result     want;
    logic [HASH_W-1:0] parent_hash = '0;
    logic              past_colon  = 1'b0;
    logic [SHARD_W-1:0] shard_cfg  = SHARD_RESET;
    int                fails       = 0;

    function automatic logic [HASH_W-1:0] sdbm_fold(input logic [HASH_W-1:0] h,
                                                     input logic [BYTE_W-1:0] b);
        return HASH_W'(b) + (h << 6) + (h << 16) - h;
    endfunction

    function automatic int shard_divisor(input logic [SHARD_W-1:0] n);
        int d;
        d = int'(n);
        if (d < 1) d = 1;
        if (d > int'(MAX_SHARDS)) d = int'(MAX_SHARDS);
        return d;
    endfunction

    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic last);
        t_shard_result r;
        if (!past_colon) begin
            if (b == SEP_BYTE) begin
                past_colon = 1'b1;
            end else begin
                parent_hash = sdbm_fold(parent_hash, b);
            end
        end
        if (last) begin
            r.hash  = parent_hash[KEY_W-1:0];
            r.shard = IDX_W'(int'(r.hash) % shard_divisor(shard_cfg));
            shard_results_q = {shard_results_q, r};
            parent_hash = '0;
            past_colon  = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shard_results_q.delete();
            parent_hash = '0;
            past_colon  = 1'b0;
            shard_cfg   = SHARD_RESET;
        end else begin
            if (i_cfg_we) begin
                shard_cfg = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_byte(i_name_byte, i_is_last);
            end
            if (i_out_valid && !i_out_stall) begin
                if (shard_results_q.size() == 0) begin
                    $display("%0t: unexpected transaction shard_index=%0d key_hash=0x%08h",
                             $time, i_shard_index, i_key_hash);
                    fails++;
                end else begin
                    want = shard_results_q.pop_front();
                    if (i_shard_index !== want.shard) begin
                        $display("%0t: shard_index mismatch: expected %0d, actual %0d",
                                 $time, want.shard, i_shard_index);
                        fails++;
                    end
                    if (i_key_hash !== want.hash) begin
                        $display("%0t: key_hash mismatch: expected 0x%08h, actual 0x%08h",
                                 $time, want.hash, i_key_hash);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= shard_results_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> tb/sv/key_hash_shard_select_tb.sv
// Testbench top for key_hash_shard_select: drives account name bytes and shard counts,
// stalls the result side, and reports the verdict from khss_checker.
// Depends on khss_pkg, khss_checker and the key_hash_shard_select RTL.
module key_hash_shard_select_tb;
    import khss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE      = 48;
    localparam int PHASE_BYTES = 240;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [SHARD_W-1:0] i_cfg_data    = '0;
    logic               i_in_valid    = 1'b0;
    logic [BYTE_W-1:0]  i_name_byte   = '0;
    logic               i_is_last     = 1'b0;
    logic               i_out_stall   = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [IDX_W-1:0]   o_shard_index;
    logic [KEY_W-1:0]   o_key_hash;

    int fail_count;
    int results_pending;
    int quiet_cycles  = 0;
    int stall_left    = 0;
    int stall_mode    = 0;
    int burst_left    = 0;
    bit driving       = 1'b0;
    bit no_idle       = 1'b0;

    key_hash_shard_select i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_name_byte   (i_name_byte),
        .i_is_last     (i_is_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_shard_index (o_shard_index),
        .o_key_hash    (o_key_hash)
    );

    khss_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_name_byte   (i_name_byte),
        .i_is_last     (i_is_last),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_shard_index (o_shard_index),
        .i_key_hash    (o_key_hash),
        .o_fail_count  (fail_count),
        .o_pending     (results_pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side stall pattern, switching at random among four modes
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_out_stall <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_out_stall <= ((stall_left % 16) < 10);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("key_hash_shard_select regression: fail");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        i_in_valid  <= 1'b1;
        i_name_byte <= b;
        i_is_last   <= last;
        driving = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (!no_idle && burst_left == 0) begin
            i_in_valid <= 1'b0;
            driving = 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic send_name(input logic [BYTE_W-1:0] name_q[$]);
        foreach (name_q[k]) begin
            send_byte(name_q[k], k == name_q.size() - 1);
        end
    endtask

    task automatic drain();
        if (driving) begin
            i_in_valid <= 1'b0;
            driving = 1'b0;
        end
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_shards(input logic [SHARD_W-1:0] n);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] parent_byte();
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 1) == 1) begin
            b = BYTE_W'($urandom_range(97, 122));
        end else begin
            b = BYTE_W'($urandom);
            if (b == SEP_BYTE) b = b ^ 8'h01;
        end
        return b;
    endfunction

    task automatic send_random_names(input int quota);
        logic [BYTE_W-1:0] name_q[$];
        int sent;
        int plen;
        int slen;
        sent = 0;
        while (sent < quota) begin
            name_q.delete();
            if ($urandom_range(0, 9) < 7) begin
                plen = ($urandom_range(0, 19) == 0) ? $urandom_range(24, 40)
                                                    : $urandom_range(0, 10);
                repeat (plen) name_q = {name_q, parent_byte()};
                if (plen == 0 || $urandom_range(0, 2) != 0) begin
                    name_q = {name_q, SEP_BYTE};
                    slen = $urandom_range(0, 8);
                    repeat (slen) begin
                        name_q = {name_q, ($urandom_range(0, 3) == 0) ? SEP_BYTE
                                                                      : BYTE_W'($urandom)};
                    end
                end
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    name_q = {name_q, ($urandom_range(0, 3) == 0) ? SEP_BYTE
                                                                  : BYTE_W'($urandom)};
                end
            end
            sent += name_q.size();
            send_name(name_q);
        end
    endtask

    initial begin
        logic [SHARD_W-1:0] shard_plan[8];
        shard_plan = '{9'd256, 9'd0, 9'd511, 9'd257, 9'd1, 9'd2, 9'd255, 9'd0};
        shard_plan[7] = SHARD_W'($urandom_range(3, 254));
        burst_left = $urandom_range(1, 16);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed names under the reset shard count
        send_name('{8'h00});
        send_name('{8'hFF});
        send_name('{SEP_BYTE});
        send_name('{8'h61, SEP_BYTE, 8'h62, SEP_BYTE, 8'h63});
        send_name('{8'hFF, 8'hFF, 8'hFF});
        send_name('{8'h78, SEP_BYTE});
        send_name('{8'h80, 8'h01, 8'h7F, 8'hAA, 8'h55, 8'hFE, 8'hFF});
        drain();

        foreach (shard_plan[p]) begin
            write_shards(shard_plan[p]);
            no_idle = (p == 3);
            if (p == 0) begin
                send_name('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
                send_name('{8'h41, 8'h42, SEP_BYTE, SEP_BYTE, 8'hFF});
            end
            send_random_names(PHASE_BYTES);
            drain();
        end

        if (fail_count == 0) begin
            $display("key_hash_shard_select regression: pass");
        end else begin
            $display("key_hash_shard_select regression: fail");
        end
        $finish;
    end

endmodule
